// ===== hw/rtl/lpg_pkg.sv =====
// Shared types and constants for the line pixel generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lpg_pkg;

  localparam int PIX_W        = 6;
  localparam int COLOR_W      = 24;
  localparam int COORD_BITS_D = 6;
  localparam int CMD_DEPTH_D  = 2;

  typedef struct packed {
    logic [PIX_W-1:0]   start_x;
    logic [PIX_W-1:0]   start_y;
    logic [PIX_W-1:0]   end_x;
    logic [PIX_W-1:0]   end_y;
    logic [COLOR_W-1:0] pen_color;
  } lpg_in_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;
  } lpg_out_t;

  typedef struct packed {
    logic [PIX_W-1:0]   maj_start;
    logic [PIX_W-1:0]   maj_end;
    logic [PIX_W-1:0]   min_start;
    logic [PIX_W-1:0]   dx;
    logic [PIX_W-1:0]   dy;
    logic               step_up;
    logic               steep;
    logic [COLOR_W-1:0] color;
  } lpg_cmd_t;

  typedef struct packed {
    logic busy;
    logic cmd_pop;
  } lpg_seq_stat_t;

endpackage

// ===== hw/rtl/lpg_front.sv =====
// Segment classifier: orders endpoints along the major axis and derives step terms.
// Depends on lpg_pkg.
`timescale 1ns / 1ps

module lpg_front import lpg_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_D
) (
  input  lpg_in_t  seg_i,
  output lpg_cmd_t cmd_o
);

  logic [COORD_BITS-1:0] ax, ay, bx, by;
  logic [COORD_BITS-1:0] adx, ady;
  logic                  steep;
  logic [COORD_BITS-1:0] p0, q0, p1, q1;
  logic                  swap;
  logic [COORD_BITS-1:0] maj0, maj1, min0, min1;
  logic [COORD_BITS-1:0] dx, dy;

  always_comb begin
    ax    = seg_i.start_x[COORD_BITS-1:0];
    ay    = seg_i.start_y[COORD_BITS-1:0];
    bx    = seg_i.end_x[COORD_BITS-1:0];
    by    = seg_i.end_y[COORD_BITS-1:0];
    adx   = (ax >= bx) ? (ax - bx) : (bx - ax);
    ady   = (ay >= by) ? (ay - by) : (by - ay);
    steep = adx < ady;
    p0    = steep ? ay : ax;
    q0    = steep ? ax : ay;
    p1    = steep ? by : bx;
    q1    = steep ? bx : by;
    swap  = p0 > p1;
    maj0  = swap ? p1 : p0;
    maj1  = swap ? p0 : p1;
    min0  = swap ? q1 : q0;
    min1  = swap ? q0 : q1;
    dx    = maj1 - maj0;
    dy    = (min1 >= min0) ? (min1 - min0) : (min0 - min1);

    cmd_o.maj_start = PIX_W'(maj0);
    cmd_o.maj_end   = PIX_W'(maj1);
    cmd_o.min_start = PIX_W'(min0);
    cmd_o.dx        = PIX_W'(dx);
    cmd_o.dy        = PIX_W'(dy);
    cmd_o.step_up   = min1 > min0;
    cmd_o.steep     = steep;
    cmd_o.color     = seg_i.pen_color;
  end

endmodule

// ===== hw/rtl/lpg_cmd_fifo.sv =====
// Short command queue between the classifier and the stepper.
// Depends on lpg_pkg; DEPTH of two or more.
`timescale 1ns / 1ps

module lpg_cmd_fifo import lpg_pkg::*; #(
  parameter int DEPTH = CMD_DEPTH_D
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en_i,
  input  lpg_cmd_t wr_data_i,
  input  logic     rd_en_i,
  output lpg_cmd_t rd_data_o,
  output logic     full_o,
  output logic     empty_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  lpg_cmd_t        mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_wr, do_rd;

  assign full_o    = count_r == CW'(DEPTH);
  assign empty_o   = count_r == '0;
  assign rd_data_o = mem_r[rd_ptr_r];
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data_i;
    end
  end

endmodule

// ===== hw/rtl/lpg_back.sv =====
// Bresenham stepper: walks one queued segment into an output register, one pixel per cycle
// while the output register is empty or popped. Depends on lpg_pkg.
`timescale 1ns / 1ps

module lpg_back import lpg_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_D
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid_i,
  input  lpg_cmd_t      cmd_i,
  output lpg_seq_stat_t stat_o,
  input  logic          pop_i,
  output logic          empty_o,
  output lpg_out_t      pix_o
);

  localparam int EW = COORD_BITS + 3;

  logic                  busy_r, busy_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [COORD_BITS-1:0] major_r, major_nxt;
  logic [COORD_BITS-1:0] end_r, end_nxt;
  logic [COORD_BITS-1:0] minor_r, minor_nxt;
  logic [COORD_BITS-1:0] dx_r, dx_nxt;
  logic [COORD_BITS-1:0] dy_r, dy_nxt;
  logic signed [EW-1:0]  err_r, err_nxt;
  logic                  step_up_r, step_up_nxt;
  logic                  steep_r, steep_nxt;
  logic [COLOR_W-1:0]    color_r, color_nxt;
  lpg_out_t              pix_r, pix_nxt;

  logic                  advance, cmd_pop, last;
  logic signed [EW-1:0]  err_sum;

  assign advance        = !out_valid_r || pop_i;
  assign cmd_pop        = !busy_r && cmd_valid_i;
  assign last           = major_r == end_r;
  assign err_sum        = err_r + $signed({2'b00, dy_r, 1'b0});
  assign stat_o.busy    = busy_r;
  assign stat_o.cmd_pop = cmd_pop;
  assign empty_o        = !out_valid_r;
  assign pix_o          = pix_r;

  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    major_nxt     = major_r;
    end_nxt       = end_r;
    minor_nxt     = minor_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    err_nxt       = err_r;
    step_up_nxt   = step_up_r;
    steep_nxt     = steep_r;
    color_nxt     = color_r;
    pix_nxt       = pix_r;

    if (cmd_pop) begin
      busy_nxt    = 1'b1;
      major_nxt   = cmd_i.maj_start[COORD_BITS-1:0];
      end_nxt     = cmd_i.maj_end[COORD_BITS-1:0];
      minor_nxt   = cmd_i.min_start[COORD_BITS-1:0];
      dx_nxt      = cmd_i.dx[COORD_BITS-1:0];
      dy_nxt      = cmd_i.dy[COORD_BITS-1:0];
      err_nxt     = '0;
      step_up_nxt = cmd_i.step_up;
      steep_nxt   = cmd_i.steep;
      color_nxt   = cmd_i.color;
    end

    if (busy_r && advance) begin
      out_valid_nxt       = 1'b1;
      pix_nxt.pixel_x     = PIX_W'(steep_r ? minor_r : major_r);
      pix_nxt.pixel_y     = PIX_W'(steep_r ? major_r : minor_r);
      pix_nxt.pixel_color = color_r;
      pix_nxt.last_pixel  = last;
      if (last) begin
        busy_nxt = 1'b0;
      end else begin
        major_nxt = major_r + 1'b1;
        if (err_sum > $signed({3'b000, dx_r})) begin
          minor_nxt = step_up_r ? minor_r + 1'b1 : minor_r - 1'b1;
          err_nxt   = err_sum - $signed({2'b00, dx_r, 1'b0});
        end else begin
          err_nxt = err_sum;
        end
      end
    end else if (pop_i) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    major_r   <= major_nxt;
    end_r     <= end_nxt;
    minor_r   <= minor_nxt;
    dx_r      <= dx_nxt;
    dy_r      <= dy_nxt;
    err_r     <= err_nxt;
    step_up_r <= step_up_nxt;
    steep_r   <= steep_nxt;
    color_r   <= color_nxt;
    pix_r     <= pix_nxt;
  end

endmodule

// ===== hw/rtl/line_pixel_generator_top.sv =====
// Line pixel generator: one segment in, its Bresenham pixel run out, one pixel per cycle
// while pop is high. With queue empty and stepper idle, the first pixel passes the queue,
// the stepper registers and out_data. A segment gives N = major-axis length + 1 pixels, up to
// 2^COORD_BITS; the single stepper in lpg_back loads a new segment only when idle.
// Reset (synchronous, rst_n low) empties the command queue and the output register.
// Depends on lpg_pkg, lpg_front, lpg_cmd_fifo, lpg_back.
`timescale 1ns / 1ps

module line_pixel_generator_top import lpg_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_D,
  parameter int CMD_DEPTH  = CMD_DEPTH_D
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  lpg_in_t  in_data,
  input  logic     pop,
  output logic     empty,
  output lpg_out_t out_data
);

  lpg_cmd_t      front_cmd, queue_cmd;
  logic          cmd_full, cmd_empty;
  lpg_seq_stat_t seq_stat;

  assign full = cmd_full;

  lpg_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .seg_i(in_data),
    .cmd_o(front_cmd)
  );

  lpg_cmd_fifo #(
    .DEPTH(CMD_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en_i  (push),
    .wr_data_i(front_cmd),
    .rd_en_i  (seq_stat.cmd_pop),
    .rd_data_o(queue_cmd),
    .full_o   (cmd_full),
    .empty_o  (cmd_empty)
  );

  lpg_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid_i(!cmd_empty),
    .cmd_i      (queue_cmd),
    .stat_o     (seq_stat),
    .pop_i      (pop),
    .empty_o    (empty),
    .pix_o      (out_data)
  );

  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_full |-> !cmd_empty)
    else $error("command queue flags full and empty together");

  a_pop_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    seq_stat.cmd_pop |-> (!cmd_empty && !seq_stat.busy))
    else $error("stepper loads a command while busy or with an empty queue");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && cmd_empty) |=> !cmd_empty)
    else $error("segment transfer did not reach the command queue");

  a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    seq_stat.cmd_pop |=> seq_stat.busy)
    else $error("stepper idle after loading a command");

endmodule

// ===== tb/sv/line_pixel_generator_tb.sv =====
// Self-checking testbench for line_pixel_generator_top: segments in, Bresenham pixel runs out.
// Predicts every pixel in SystemVerilog and checks each output transfer in order.
// Depends on lpg_pkg and line_pixel_generator_top.
`timescale 1ns / 1ps

module testbench;
  import lpg_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 7;
  localparam int TIMEOUT_CYCLES = 2000000;
  localparam int TAIL_CYCLES    = 70;
  localparam int HOLD_CYCLES    = 400;
  localparam int REPORT_MAX     = 10;

  typedef enum int {RX_STREAM, RX_COIN, RX_MOSTLY, RX_EVERY_THIRD} rx_mode_e;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     push;
  logic     full;
  lpg_in_t  in_data;
  logic     pop;
  logic     empty;
  lpg_out_t out_data;

  lpg_out_t pixel_q[$];
  lpg_out_t want_pixel;
  int       mismatches  = 0;
  int       segs_sent   = 0;
  int       pixels_seen = 0;

  bit       hold_request = 1'b0;
  int       hold_cnt     = 0;
  rx_mode_e rx_mode      = RX_STREAM;
  int       mode_left    = 0;
  int       rx_phase     = 0;

  line_pixel_generator_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

  always #(CLK_HALF) clk = ~clk;

  function automatic int mag(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic lpg_in_t seg(input int ax, input int ay, input int bx, input int by,
                                  input logic [COLOR_W-1:0] color);
    lpg_in_t s;
    s.start_x   = ax[PIX_W-1:0];
    s.start_y   = ay[PIX_W-1:0];
    s.end_x     = bx[PIX_W-1:0];
    s.end_y     = by[PIX_W-1:0];
    s.pen_color = color;
    return s;
  endfunction

  // Walk the major axis low to high, stepping the minor coordinate on error overflow.
  function automatic void predict_pixels(input lpg_in_t s);
    int       ax, ay, bx, by, t, dx, dy, two_dy, err, minor, step, major;
    bit       steep;
    lpg_out_t p;
    ax = int'(s.start_x);
    ay = int'(s.start_y);
    bx = int'(s.end_x);
    by = int'(s.end_y);
    steep = (mag(bx - ax) < mag(by - ay));
    if (steep) begin
      t = ax; ax = ay; ay = t;
      t = bx; bx = by; by = t;
    end
    if (ax > bx) begin
      t = ax; ax = bx; bx = t;
      t = ay; ay = by; by = t;
    end
    dx = bx - ax;
    dy = by - ay;
    two_dy = 2 * mag(dy);
    step = (by > ay) ? 1 : -1;
    err = 0;
    minor = ay;
    for (major = ax; major <= bx; major++) begin
      p.pixel_x     = steep ? minor[PIX_W-1:0] : major[PIX_W-1:0];
      p.pixel_y     = steep ? major[PIX_W-1:0] : minor[PIX_W-1:0];
      p.pixel_color = s.pen_color;
      p.last_pixel  = (major == bx);
      pixel_q.push_back(p);
      err += two_dy;
      if (err > dx) begin
        minor += step;
        err -= 2 * dx;
      end
    end
  endfunction

  task automatic send_segment(input lpg_in_t s);
    @(negedge clk);
    push    <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (full);
    predict_pixels(s);
    segs_sent++;
  endtask

  task automatic sender_gap(input int n);
    repeat (n) begin
      @(negedge clk);
      push <= 1'b0;
    end
  endtask

  task automatic wait_all_pixels();
    while (pixel_q.size() != 0) @(posedge clk);
  endtask

  function automatic int clamp_coord(input int v);
    return (v < 0) ? 0 : ((v > 63) ? 63 : v);
  endfunction

  function automatic lpg_in_t random_segment();
    int ax, ay, bx, by, len, kind;
    ax = $urandom_range(0, 63);
    ay = $urandom_range(0, 63);
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: begin
        bx = $urandom_range(0, 63);
        by = $urandom_range(0, 63);
      end
      4, 5, 6: begin
        bx = clamp_coord(ax + $urandom_range(0, 8) - 4);
        by = clamp_coord(ay + $urandom_range(0, 8) - 4);
      end
      7: begin
        bx = $urandom_range(0, 1) ? $urandom_range(0, 63) : ax;
        by = (bx == ax) ? $urandom_range(0, 63) : ay;
      end
      8: begin
        len = $urandom_range(0, 20);
        bx = clamp_coord($urandom_range(0, 1) ? ax + len : ax - len);
        by = clamp_coord($urandom_range(0, 1) ? ay + mag(bx - ax) : ay - mag(bx - ax));
        if (mag(by - ay) != mag(bx - ax)) bx = ax + ((bx > ax) ? mag(by - ay) : -mag(by - ay));
      end
      default: begin
        bx = clamp_coord(ax + $urandom_range(0, 6) - 3);
        by = $urandom_range(0, 63);
      end
    endcase
    return seg(ax, ay, bx, by, COLOR_W'($urandom()));
  endfunction

  task automatic test_directed();
    send_segment(seg(0, 0, 0, 0, 24'h000000));
    send_segment(seg(63, 63, 63, 63, 24'hFFFFFF));
    send_segment(seg(0, 0, 63, 0, 24'hAAAAAA));
    send_segment(seg(63, 63, 0, 63, 24'h555555));
    send_segment(seg(0, 0, 0, 63, 24'h800001));
    send_segment(seg(63, 63, 63, 0, 24'h7FFFFE));
    send_segment(seg(0, 0, 63, 63, 24'hFFFFFF));
    send_segment(seg(63, 0, 0, 63, 24'h000000));
    send_segment(seg(10, 20, 30, 5, 24'hAAAAAA));
    send_segment(seg(30, 5, 10, 20, 24'h555555));
    send_segment(seg(5, 10, 12, 60, 24'h800001));
    send_segment(seg(40, 60, 35, 2, 24'h7FFFFE));
    send_segment(seg(20, 40, 50, 41, 24'h123456));
    send_segment(seg(1, 2, 2, 1, 24'hFEDCBA));
    send_segment(seg(33, 33, 34, 35, 24'h0F0F0F));
    send_segment(seg(7, 3, 0, 0, 24'hF0F0F0));
    sender_gap(1);
    wait_all_pixels();
  endtask

  task automatic test_random_bursts(input int count);
    int sent, burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 10);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_segment(random_segment());
        sent++;
      end
      sender_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12));
    end
    sender_gap(1);
  endtask

  task automatic test_backpressure();
    hold_request = 1'b1;
    for (int i = 0; i < 12; i++) send_segment(random_segment());
    sender_gap(1);
    wait_all_pixels();
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 6; i++) send_segment(random_segment());
    sender_gap(1);
    wait_all_pixels();
    sender_gap(TAIL_CYCLES);
    for (int i = 0; i < 6; i++) send_segment(random_segment());
    sender_gap(1);
    wait_all_pixels();
  endtask

  // Receiver: hold off on request, otherwise stall on a slowly changing pattern.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_cnt = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (mode_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    if (rst_n !== 1'b1 || hold_cnt > 0) begin
      pop <= 1'b0;
      if (hold_cnt > 0) hold_cnt--;
    end else begin
      case (rx_mode)
        RX_STREAM: pop <= 1'b1;
        RX_COIN:   pop <= 1'($urandom_range(0, 1));
        RX_MOSTLY: pop <= ($urandom_range(0, 3) != 0);
        default: begin
          pop <= (rx_phase == 0);
          rx_phase = (rx_phase + 1) % 3;
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && pop === 1'b1 && empty === 1'b0) begin
      pixels_seen++;
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected pixel x=%0d y=%0d color=%06h last=%0b", out_data.pixel_x,
                   out_data.pixel_y, out_data.pixel_color, out_data.last_pixel);
      end else begin
        want_pixel = pixel_q.pop_front();
        if (out_data.pixel_x !== want_pixel.pixel_x || out_data.pixel_y !== want_pixel.pixel_y ||
            out_data.pixel_color !== want_pixel.pixel_color ||
            out_data.last_pixel !== want_pixel.last_pixel) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("exp x=%0d y=%0d c=%06h l=%0b, got x=%0d y=%0d c=%06h l=%0b",
                     want_pixel.pixel_x, want_pixel.pixel_y, want_pixel.pixel_color,
                     want_pixel.last_pixel, out_data.pixel_x, out_data.pixel_y,
                     out_data.pixel_color, out_data.last_pixel);
        end
      end
    end
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("timeout with %0d pixels outstanding", pixel_q.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_n   = 1'b0;
    push    = 1'b0;
    pop     = 1'b0;
    in_data = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_bursts(120);
    test_backpressure();
    test_drain_pause();
    test_random_bursts(120);

    wait_all_pixels();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pixel_q.size() != 0) mismatches += pixel_q.size();
    $display("Drew %0d segments and checked %0d pixels: directed edge cases, random bursts,",
             segs_sent, pixels_seen);
    $display("a long output hold-off with input backpressure, and a full drain pause.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching or missing pixels", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/lpg_pkg.sv
hw/rtl/lpg_front.sv
hw/rtl/lpg_cmd_fifo.sv
hw/rtl/lpg_back.sv
hw/rtl/line_pixel_generator_top.sv
tb/sv/line_pixel_generator_tb.sv
